// ===== src/aqr_pkg.sv =====
// Shared constants for the quaternion box rotation block.
// No dependencies; imported by the top level, the row unit and the checker.
`default_nettype none
package aqr_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int QUAT_WIDTH_DEF  = 16;
   localparam int PIPE_DEPTH      = 6;
endpackage
`default_nettype wire

// ===== src/aqr_row.sv =====
// One output axis: products, per-column extremes, sums, round and saturate.
// Depends on aqr_pkg for default widths.
`default_nettype none
module aqr_row import aqr_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF,
   parameter int QW = QUAT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic signed [2*QW+2:0] mat_entry [3],
   input  logic signed [CW-1:0] lo_coord [3],
   input  logic signed [CW-1:0] hi_coord [3],
   output logic signed [CW-1:0] new_low,
   output logic signed [CW-1:0] new_high
);
   localparam int MW = 2*QW + 3;
   localparam int PW = MW + CW;
   localparam int SW = PW + 3;
   localparam int PSHIFT = 2*(QW - 2);

   logic signed [PW-1:0] plo_ff [3];
   logic signed [PW-1:0] phi_ff [3];
   logic signed [PW-1:0] mn_ff [3];
   logic signed [PW-1:0] mx_ff [3];
   logic signed [SW-1:0] slo_ff, shi_ff;
   logic signed [SW-1:0] slo_in, shi_in, rlo, rhi;
   logic signed [CW-1:0] new_low_ff, new_high_ff, low_in, high_in;

   function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] r);
      logic signed [SW-1:0] sh;
      sh = r >>> PSHIFT;
      if (sh[SW-1] && !(&sh[SW-1:CW-1])) begin
         sat = {1'b1, {(CW-1){1'b0}}};
      end else if (!sh[SW-1] && (|sh[SW-1:CW-1])) begin
         sat = {1'b0, {(CW-1){1'b1}}};
      end else begin
         sat = sh[CW-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         plo_ff[c] <= PW'(mat_entry[c]) * PW'(lo_coord[c]);
         phi_ff[c] <= PW'(mat_entry[c]) * PW'(hi_coord[c]);
         mn_ff[c]  <= (plo_ff[c] < phi_ff[c]) ? plo_ff[c] : phi_ff[c];
         mx_ff[c]  <= (plo_ff[c] < phi_ff[c]) ? phi_ff[c] : plo_ff[c];
      end
      slo_ff      <= slo_in;
      shi_ff      <= shi_in;
      new_low_ff  <= low_in;
      new_high_ff <= high_in;
   end

   always_comb begin
      slo_in  = SW'(mn_ff[0]) + SW'(mn_ff[1]) + SW'(mn_ff[2]);
      shi_in  = SW'(mx_ff[0]) + SW'(mx_ff[1]) + SW'(mx_ff[2]);
      rlo     = slo_ff + (SW'(1) <<< (PSHIFT - 1));
      rhi     = shi_ff + (SW'(1) <<< (PSHIFT - 1));
      low_in  = sat(rlo);
      high_in = sat(rhi);
   end

   assign new_low  = new_low_ff;
   assign new_high = new_high_ff;
endmodule
`default_nettype wire

// ===== src/aabb_quaternion_rotate.sv =====
// Top level: rotates an axis-aligned box by a quaternion and returns its new bounds.
// Depends on aqr_pkg and aqr_row.
//
// Channel   Direction  Transfer condition
// request   in         req_start && !busy (busy is always low)
// response  out        rsp_valid, one cycle per result
//
// One item per cycle, with no stall between accepted request and response strobe.
// Stages: quaternion products, matrix entries, entry-by-coordinate products,
// per-column extremes, row sums, round and saturate.
// Reset clears only the valid pipeline; the receiver cannot stall, so nothing ever waits.
`default_nettype none
module aabb_quaternion_rotate import aqr_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_low_x,
   input  logic signed [COORD_WIDTH-1:0] req_low_y,
   input  logic signed [COORD_WIDTH-1:0] req_low_z,
   input  logic signed [COORD_WIDTH-1:0] req_high_x,
   input  logic signed [COORD_WIDTH-1:0] req_high_y,
   input  logic signed [COORD_WIDTH-1:0] req_high_z,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_w,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0]  req_quat_z,
   output logic                          rsp_valid,
   output logic signed [COORD_WIDTH-1:0] rsp_new_low_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_low_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_low_z,
   output logic signed [COORD_WIDTH-1:0] rsp_new_high_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_high_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_high_z
);
   localparam int CW = COORD_WIDTH;
   localparam int QW = QUAT_WIDTH;
   localparam int QP = 2*QW;
   localparam int MW = 2*QW + 3;
   localparam int PSHIFT = 2*(QW - 2);

   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic signed [QP-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff, wx_ff, wy_ff, wz_ff;
   logic signed [CW-1:0] lo1_ff [3];
   logic signed [CW-1:0] hi1_ff [3];
   logic signed [CW-1:0] lo2_ff [3];
   logic signed [CW-1:0] hi2_ff [3];
   logic signed [MW-1:0] mat_ff [3][3];
   logic signed [MW-1:0] mat_in [3][3];
   logic signed [MW-1:0] one;
   logic signed [CW-1:0] new_low [3];
   logic signed [CW-1:0] new_high [3];

   always_comb begin
      valid_in = {valid_ff[PIPE_DEPTH-2:0], req_start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xx_ff <= QP'(req_quat_x) * QP'(req_quat_x);
      yy_ff <= QP'(req_quat_y) * QP'(req_quat_y);
      zz_ff <= QP'(req_quat_z) * QP'(req_quat_z);
      xy_ff <= QP'(req_quat_x) * QP'(req_quat_y);
      xz_ff <= QP'(req_quat_x) * QP'(req_quat_z);
      yz_ff <= QP'(req_quat_y) * QP'(req_quat_z);
      wx_ff <= QP'(req_quat_w) * QP'(req_quat_x);
      wy_ff <= QP'(req_quat_w) * QP'(req_quat_y);
      wz_ff <= QP'(req_quat_w) * QP'(req_quat_z);
      lo1_ff[0] <= req_low_x;
      lo1_ff[1] <= req_low_y;
      lo1_ff[2] <= req_low_z;
      hi1_ff[0] <= req_high_x;
      hi1_ff[1] <= req_high_y;
      hi1_ff[2] <= req_high_z;
      lo2_ff <= lo1_ff;
      hi2_ff <= hi1_ff;
      mat_ff <= mat_in;
   end

   always_comb begin
      one = MW'(1) <<< PSHIFT;
      mat_in[0][0] = one - ((MW'(yy_ff) + MW'(zz_ff)) <<< 1);
      mat_in[0][1] = (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
      mat_in[0][2] = (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
      mat_in[1][0] = (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
      mat_in[1][1] = one - ((MW'(xx_ff) + MW'(zz_ff)) <<< 1);
      mat_in[1][2] = (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
      mat_in[2][0] = (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
      mat_in[2][1] = (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
      mat_in[2][2] = one - ((MW'(xx_ff) + MW'(yy_ff)) <<< 1);
   end

   for (genvar r = 0; r < 3; r++) begin : g_row
      aqr_row #(.CW(CW), .QW(QW)) u_row (
         .clock     (clock),
         .mat_entry (mat_ff[r]),
         .lo_coord  (lo2_ff),
         .hi_coord  (hi2_ff),
         .new_low   (new_low[r]),
         .new_high  (new_high[r])
      );
   end

   assign busy           = 1'b0;
   assign rsp_valid      = valid_ff[PIPE_DEPTH-1];
   assign rsp_new_low_x  = new_low[0];
   assign rsp_new_low_y  = new_low[1];
   assign rsp_new_low_z  = new_low[2];
   assign rsp_new_high_x = new_high[0];
   assign rsp_new_high_y = new_high[1];
   assign rsp_new_high_z = new_high[2];
endmodule
`default_nettype wire

// ===== src/aqr_checker.sv =====
// Port-level checks for the box rotation top level, attached by bind.
// Depends on aqr_pkg and aabb_quaternion_rotate.
`default_nettype none
module aqr_checker import aqr_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_start,
   input wire logic                          busy,
   input wire logic                          rsp_valid,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_low_x,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_low_y,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_low_z,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_high_x,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_high_y,
   input wire logic signed [COORD_WIDTH-1:0] rsp_new_high_z
);
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_valid_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start, PIPE_DEPTH))
      else $error("response without a matching request");

   a_start_gives_valid: assert property (@(posedge clock) disable iff (reset)
      req_start |-> ##PIPE_DEPTH rsp_valid)
      else $error("request transfer lost");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_new_low_x <= rsp_new_high_x) && (rsp_new_low_y <= rsp_new_high_y)
                    && (rsp_new_low_z <= rsp_new_high_z))
      else $error("response bounds out of order");
endmodule

bind aabb_quaternion_rotate aqr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_aqr_checker (.*);
`default_nettype wire
